// ----- rtl/bantbl_pkg.sv -----
// Shared types, codes and helpers for the wildcard IPv4 ban table.
package bantbl_pkg;

   // Default number of ban entries
   localparam int DEFAULT_TABLE_DEPTH = 64;

   // Pattern byte that matches any address byte
   localparam logic [7:0] WILDCARD_BYTE = 8'hFF;

   // Operation codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CHECK = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Status codes
   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_TEMP = 2'd1;
   localparam logic [1:0] ST_PERM = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   // Request transaction
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  ip_b1;
      logic [7:0]  ip_b2;
      logic [7:0]  ip_b3;
      logic [7:0]  ip_b4;
      logic [31:0] expire_time;
      logic [31:0] now_time;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] seconds_left;
   } rsp_type;

   // One table entry as held in the memory
   typedef struct packed {
      logic        valid;
      logic [31:0] pattern;
      logic [31:0] expiry;
   } entry_type;

   // True when every pattern byte is a wildcard or equals the address byte
   function automatic logic pattern_hits(input logic [31:0] pat, input logic [31:0] addr);
      logic hit;
      hit = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (pat[k*8 +: 8] != WILDCARD_BYTE && pat[k*8 +: 8] != addr[k*8 +: 8]) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage

// ----- rtl/bantbl_ram.sv -----
// Single-port-write, single-port-read entry memory with registered read data.
module bantbl_ram #(
   parameter int TABLE_DEPTH = bantbl_pkg::DEFAULT_TABLE_DEPTH,
   parameter int AW          = 6
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output bantbl_pkg::entry_type rd_data,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  bantbl_pkg::entry_type wr_data
);

   bantbl_pkg::entry_type mem_ff [TABLE_DEPTH];
   bantbl_pkg::entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bantbl_ctrl.sv -----
// Sequencer: clearing pass, table scan for add and check, and result hold.
module bantbl_ctrl #(
   parameter int TABLE_DEPTH = bantbl_pkg::DEFAULT_TABLE_DEPTH,
   parameter int AW          = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bantbl_pkg::req_type   req_payload,
   output logic                  ram_rd_en,
   output logic [AW-1:0]         ram_rd_addr,
   input  bantbl_pkg::entry_type ram_rd_data,
   output logic                  ram_wr_en,
   output logic [AW-1:0]         ram_wr_addr,
   output bantbl_pkg::entry_type ram_wr_data,
   output logic                  done_valid,
   output bantbl_pkg::rsp_type   done_payload,
   input  logic                  done_take
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                rvld_ff, rvld_in;
   logic [AW-1:0]       daddr_ff, daddr_in;
   bantbl_pkg::req_type req_ff, req_in;
   bantbl_pkg::rsp_type result_ff, result_in;

   logic        cnt_lt;
   logic        last_data;
   logic        is_add;
   logic        hit;
   logic [31:0] addr;
   logic [31:0] left_diff;

   // Scan bookkeeping
   assign addr      = {req_ff.ip_b1, req_ff.ip_b2, req_ff.ip_b3, req_ff.ip_b4};
   assign cnt_lt    = cnt_ff < CW'(TABLE_DEPTH);
   assign last_data = daddr_ff == AW'(TABLE_DEPTH - 1);
   assign is_add    = req_ff.op == bantbl_pkg::OP_ADD;
   assign left_diff = ram_rd_data.expiry - req_ff.now_time;

   // Add wants the first free slot, check the first valid matching entry
   always_comb begin
      if (is_add) begin
         hit = rvld_ff && !ram_rd_data.valid;
      end else begin
         hit = rvld_ff && ram_rd_data.valid &&
               bantbl_pkg::pattern_hits(ram_rd_data.pattern, addr);
      end
   end

   // Next state and memory access
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rvld_in     = 1'b0;
      daddr_in    = cnt_ff[AW-1:0];
      req_in      = req_ff;
      result_in   = result_ff;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = daddr_ff;
      ram_wr_data = '0;
      case (state_ff)
         S_INIT, S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[AW-1:0];
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff[AW-1:0] == AW'(TABLE_DEPTH - 1)) begin
               state_in  = (state_ff == S_INIT) ? S_IDLE : S_DONE;
               result_in = '0;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_payload;
               cnt_in    = '0;
               result_in = '0;
               case (req_payload.op)
                  bantbl_pkg::OP_ADD, bantbl_pkg::OP_CHECK: state_in = S_SCAN;
                  bantbl_pkg::OP_CLEAR:                     state_in = S_CLEAR;
                  default:                                  state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            // Issue one read per cycle until a hit or the end of the table
            if (cnt_lt && !hit) begin
               ram_rd_en = 1'b1;
               rvld_in   = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (hit) begin
               state_in  = S_DONE;
               result_in = '0;
               if (is_add) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = '{valid: 1'b1, pattern: addr, expiry: req_ff.expire_time};
               end else if (ram_rd_data.expiry > req_ff.now_time) begin
                  result_in.status       = bantbl_pkg::ST_TEMP;
                  result_in.seconds_left = left_diff;
               end else if (ram_rd_data.expiry != 32'd0) begin
                  // Expired ban: free the entry
                  ram_wr_en   = 1'b1;
                  ram_wr_data = '{valid: 1'b0, pattern: ram_rd_data.pattern,
                                  expiry: ram_rd_data.expiry};
               end else begin
                  result_in.status = bantbl_pkg::ST_PERM;
               end
            end else if (rvld_ff && last_data) begin
               state_in  = S_DONE;
               result_in = '0;
               if (is_add) begin
                  result_in.status = bantbl_pkg::ST_FULL;
               end
            end
         end
         S_DONE: begin
            if (done_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ram_rd_addr  = cnt_ff[AW-1:0];
   assign req_stall    = state_ff != S_IDLE;
   assign done_valid   = state_ff == S_DONE;
   assign done_payload = result_ff;

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rvld_ff  <= rvld_in;
      end
      daddr_ff  <= daddr_in;
      req_ff    <= req_in;
      result_ff <= result_in;
   end

endmodule

// ----- rtl/wildcard_ip_ban_table_top.sv -----
// Wildcard IPv4 ban table: entry memory, scan sequencer and response register.
// Add and check scan the entries in order and stop at the first hit; a miss or a full
// table scans every entry, clear rewrites every entry, and op 3 goes straight to status none.
// One transaction at a time; the scan reads one entry per cycle.
// Reset: synchronous; a clearing pass writes every entry invalid, with req_stall high
// until it ends.
module wildcard_ip_ban_table_top #(
   parameter int TABLE_DEPTH = bantbl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bantbl_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bantbl_pkg::rsp_type rsp_payload
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   bantbl_pkg::entry_type ram_rd_data;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   bantbl_pkg::entry_type ram_wr_data;
   logic                  done_valid;
   bantbl_pkg::rsp_type   done_payload;
   logic                  done_take;

   logic                rsp_valid_ff, rsp_valid_in;
   bantbl_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   bantbl_ram #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   bantbl_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .done_valid   (done_valid),
      .done_payload (done_payload),
      .done_take    (done_take)
   );

   // Response register loads when empty or draining
   assign done_take = done_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (done_take) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = done_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The clearing pass holds off requests right after reset
   a_init_stall: assert property (@(posedge clock) (!reset && $past(reset)) |-> req_stall)
      else $error("request not stalled during clearing pass");

   // One transaction in flight: an accepted request stalls the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   // Temporary ban always carries time left
   a_temp_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == bantbl_pkg::ST_TEMP) |->
      rsp_payload.seconds_left != 32'd0)
      else $error("temporary ban with zero seconds left");

   // Other statuses carry no time
   a_other_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != bantbl_pkg::ST_TEMP) |->
      rsp_payload.seconds_left == 32'd0)
      else $error("seconds left on a non-temporary status");

endmodule
